// File: design/l2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l2d_pkg
// Shared constants and types of the int8 squared L2 distance engine.
// ----------------------------------------------------------------------------
package l2d_pkg;

   // default sizing, overridable on the top level
   localparam int MAX_DIMENSION_DEF = 4096;
   localparam int LANES_DEF         = 8;

   // fixed field widths
   localparam int ELEM_W    = 8;
   localparam int SQ_W      = 16;
   localparam int ACC_W     = 29;
   localparam int DIST_W    = 28;
   localparam int DIM_REG_W = 13;

   localparam logic [DIM_REG_W-1:0] DIM_RESET = 13'd128;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_DIMENSION = 1'b0;

   // item commands
   localparam logic CMD_LOAD     = 1'b0;
   localparam logic CMD_DATABASE = 1'b1;

   // control that travels with a database item down the pipeline
   typedef struct packed {
      logic valid;
      logic last;
      logic batch_end;
   } stage_ctl_type;

endpackage

// File: design/l2d_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l2d channel interfaces
// Request channel (query load and database items) and result channel.
// ----------------------------------------------------------------------------
interface l2d_req_if #(
   parameter int LANES = l2d_pkg::LANES_DEF
);
   import l2d_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic [LANES*ELEM_W-1:0]   lane;
   logic                      batch_end;

   modport source (output valid, cmd, lane, batch_end, input ready);
   modport sink   (input valid, cmd, lane, batch_end, output ready);
endinterface

interface l2d_rsp_if;
   import l2d_pkg::*;

   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance;
   logic              batch_done;

   modport source (output valid, distance, batch_done, input ready);
   modport sink   (input valid, distance, batch_done, output ready);
endinterface

// File: design/l2d_qstore.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l2d_qstore
// Query vector store: one word per item, byte-masked write, registered read.
// ----------------------------------------------------------------------------
module l2d_qstore #(
   parameter int LANES = l2d_pkg::LANES_DEF,
   parameter int DEPTH = 512,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int DATA_W = LANES * l2d_pkg::ELEM_W
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [LANES-1:0]  wr_mask,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data_ff
);
   import l2d_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];

   // byte-masked write of the lanes inside the dimension
   always_ff @(posedge clock) begin
      for (int k = 0; k < LANES; k++) begin
         if (wr_en && wr_mask[k]) begin
            mem[wr_addr][k*ELEM_W +: ELEM_W] <= wr_data[k*ELEM_W +: ELEM_W];
         end
      end
   end

   // registered read, held while the pipeline stalls
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// File: design/l2d_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l2d_lane
// One lane: difference of query and database element, squared and registered.
// ----------------------------------------------------------------------------
module l2d_lane (
   input  logic                       clock,
   input  logic                       adv,
   input  logic                       en,
   input  logic [l2d_pkg::ELEM_W-1:0] q_elem,
   input  logic [l2d_pkg::ELEM_W-1:0] d_elem,
   output logic [l2d_pkg::SQ_W-1:0]   sq_ff
);
   import l2d_pkg::*;

   logic signed [ELEM_W:0]     diff;
   logic signed [2*ELEM_W+1:0] prod;
   logic [SQ_W-1:0]            sq_in;

   // nine-bit difference, square fits in sixteen unsigned bits
   always_comb begin
      diff  = $signed({q_elem[ELEM_W-1], q_elem}) - $signed({d_elem[ELEM_W-1], d_elem});
      prod  = diff * diff;
      sq_in = en ? prod[SQ_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff <= sq_in;
      end
   end

endmodule

// File: design/l2d_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l2d_merge
// Sums the lane squares, accumulates per vector and holds the result item.
// ----------------------------------------------------------------------------
module l2d_merge #(
   parameter int LANES = l2d_pkg::LANES_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    adv,
   input  logic                                    clear,
   input  l2d_pkg::stage_ctl_type                  ctl2,
   input  logic [LANES-1:0][l2d_pkg::SQ_W-1:0]     sq,
   l2d_rsp_if.source                               rsp
);
   import l2d_pkg::*;

   localparam int SUM_W = SQ_W + $clog2(LANES + 1);

   logic [SUM_W-1:0]  sum_in;
   logic [SUM_W-1:0]  sum_ff;
   stage_ctl_type     ctl3_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [ACC_W-1:0]  acc_sum;
   logic              out_valid_ff;
   logic [DIST_W-1:0] out_dist_ff;
   logic              out_done_ff;

   // sum of the lane squares
   always_comb begin
      sum_in = '0;
      for (int k = 0; k < LANES; k++) begin
         sum_in = sum_in + SUM_W'(sq[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff <= '0;
      end else if (adv) begin
         ctl3_ff <= ctl2;
      end
   end

   assign acc_sum = acc_ff + ACC_W'(sum_ff);

   // accumulator, cleared at the end of each vector and on a dimension write
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         acc_ff <= '0;
      end else if (adv && ctl3_ff.valid) begin
         acc_ff <= ctl3_ff.last ? '0 : acc_sum;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= ctl3_ff.valid && ctl3_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_dist_ff <= acc_sum[DIST_W-1:0];
         out_done_ff <= ctl3_ff.batch_end;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.distance   = out_dist_ff;
   assign rsp.batch_done = out_done_ff;

endmodule

// File: design/int8_squared_l2_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_squared_l2_distance
// Squared Euclidean distance of int8 database vectors to a stored query.
// ----------------------------------------------------------------------------
// One item of LANES signed bytes is accepted in every cycle while the result
// register is free or being taken; query loads and database items run at the
// same rate. A database item passes through the store read, the lane squarers,
// the lane sum and the accumulator, and the distance of a vector is then held
// in the result register after its last item. Only a result that is not taken
// stalls the pipeline. The query store is one memory with one write and one
// read port and needs no clearing after reset; writing the dimension register
// restarts the current vector.
module int8_squared_l2_distance #(
   parameter int MAX_DIMENSION = l2d_pkg::MAX_DIMENSION_DEF,
   parameter int LANES         = l2d_pkg::LANES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   l2d_req_if.sink                            req_chan,
   l2d_rsp_if.source                          rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [l2d_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [l2d_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [l2d_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import l2d_pkg::*;

   localparam int DEPTH  = (MAX_DIMENSION + LANES - 1) / LANES;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
   localparam int EXT_W  = (DIM_W > DIM_REG_W) ? DIM_W : DIM_REG_W;
   localparam int POS_W  = $clog2(MAX_DIMENSION + LANES);
   localparam int CMP_W  = (EXT_W > POS_W) ? EXT_W : POS_W;
   localparam int DATA_W = LANES * ELEM_W;

   logic [DIM_REG_W-1:0] dim_ff;
   logic [POS_W-1:0]     pos_ff;
   logic [ADDR_W-1:0]    word_ff;
   logic [CMP_W-1:0]     eff_dim;
   logic [CMP_W-1:0]     pos_ext;
   logic [CMP_W-1:0]     next_ext;
   logic [LANES-1:0]     lane_mask;
   logic                 vec_done;
   logic                 adv;
   logic                 accept;
   logic                 is_db;
   logic                 csr_wr;
   logic                 dim_wr;
   stage_ctl_type        ctl1_in;
   stage_ctl_type        ctl1_ff;
   stage_ctl_type        ctl2_ff;
   logic [LANES-1:0]     mask1_ff;
   logic [DATA_W-1:0]    lane1_ff;
   logic [DATA_W-1:0]    q_word;
   logic [LANES-1:0][SQ_W-1:0] sq;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign dim_wr     = csr_wr && (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_DIMENSION);

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_DIMENSION) begin
         csr_prdata = CSR_DATA_W'(dim_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= DIM_RESET;
      end else if (dim_wr) begin
         dim_ff <= csr_pwdata[DIM_REG_W-1:0];
      end
   end

   // effective dimension, clamped to at least one and at most MAX_DIMENSION
   always_comb begin
      if (dim_ff == '0) begin
         eff_dim = CMP_W'(1);
      end else if (CMP_W'(dim_ff) > CMP_W'(MAX_DIMENSION)) begin
         eff_dim = CMP_W'(MAX_DIMENSION);
      end else begin
         eff_dim = CMP_W'(dim_ff);
      end
   end

   // handshake: the pipeline moves whenever the result register can take
   assign adv            = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign accept         = req_chan.valid && adv;
   assign is_db          = (req_chan.cmd == CMD_DATABASE);

   // lanes inside the dimension and end of vector
   always_comb begin
      pos_ext  = CMP_W'(pos_ff);
      next_ext = pos_ext + CMP_W'(LANES);
      vec_done = !(next_ext < eff_dim);
      for (int k = 0; k < LANES; k++) begin
         lane_mask[k] = (pos_ext + CMP_W'(k)) < eff_dim;
      end
   end

   // element position and store word
   always_ff @(posedge clock) begin
      if (reset || dim_wr) begin
         pos_ff  <= '0;
         word_ff <= '0;
      end else if (accept) begin
         if (vec_done) begin
            pos_ff  <= '0;
            word_ff <= '0;
         end else begin
            pos_ff  <= next_ext[POS_W-1:0];
            word_ff <= word_ff + ADDR_W'(1);
         end
      end
   end

   l2d_qstore #(
      .LANES (LANES),
      .DEPTH (DEPTH)
   ) u_qstore (
      .clock      (clock),
      .wr_en      (accept && !is_db),
      .wr_addr    (word_ff),
      .wr_mask    (lane_mask),
      .wr_data    (req_chan.lane),
      .rd_en      (adv),
      .rd_addr    (word_ff),
      .rd_data_ff (q_word)
   );

   // database items enter the pipeline, loads stop at the store
   always_comb begin
      ctl1_in.valid     = accept && is_db;
      ctl1_in.last      = vec_done;
      ctl1_in.batch_end = req_chan.batch_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
      end else if (adv) begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mask1_ff <= lane_mask;
         lane1_ff <= req_chan.lane;
      end
   end

   // lane squarers
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      l2d_lane u_lane (
         .clock  (clock),
         .adv    (adv),
         .en     (mask1_ff[g]),
         .q_elem (q_word[g*ELEM_W +: ELEM_W]),
         .d_elem (lane1_ff[g*ELEM_W +: ELEM_W]),
         .sq_ff  (sq[g])
      );
   end

   l2d_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .clear (dim_wr),
      .ctl2  (ctl2_ff),
      .sq    (sq),
      .rsp   (rsp_chan)
   );

`ifndef SYNTHESIS
   // position stays inside the vector
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(pos_ff) < eff_dim)
      else $error("element position beyond dimension");

   // store word tracks the element position
   a_word_tracks_pos: assert property (@(posedge clock) disable iff (reset)
      (int'(word_ff) * LANES) == int'(pos_ff))
      else $error("store word out of step with position");

   // a stalled pipeline holds its first stage
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(ctl1_ff) && $stable(mask1_ff))
      else $error("first stage changed during stall");
`endif

endmodule

// File: tb/tb_int8_squared_l2_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_int8_squared_l2_distance
// Self-checking bench for the int8 squared L2 distance engine. A shadow
// distance calculator, with its own query store, position and accumulator,
// predicts every distance. Items come from a queue that one initial block
// fills phase by phase, each phase at its own dimension setting. A clocked
// driver and a clocked monitor throttle both channels at random, and the
// monitor compares every distance with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_int8_squared_l2_distance;
   import l2d_pkg::*;

   localparam int LANE_BITS      = LANES_DEF * ELEM_W;
   localparam int DRAIN_CYCLES   = 8;
   localparam int IDLE_GUARD     = 50000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int IDLE_PCT       = 22;
   localparam int unsigned TIMEOUT_NS = 400000;

   localparam logic [CSR_ADDR_W-1:0] DIM_ADDR   = CSR_ADDR_W'(4 * CSR_IDX_DIMENSION);
   // first address past the register list
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = CSR_ADDR_W'(4 * (CSR_IDX_DIMENSION + 1));

   typedef struct {
      logic                 cmd;
      logic [LANE_BITS-1:0] lanes;
      logic                 batch_end;
   } chunk_type;

   typedef struct {
      logic [DIST_W-1:0] distance;
      logic              batch_done;
   } distance_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   l2d_req_if #(.LANES(LANES_DEF)) req_chan ();
   l2d_rsp_if rsp_chan ();

   int8_squared_l2_distance #(
      .MAX_DIMENSION(MAX_DIMENSION_DEF),
      .LANES(LANES_DEF)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // queues between generator, driver and monitor
   chunk_type    pending_chunks[$];
   distance_type expected_distances[$];

   int mismatch_count   = 0;
   int chunks_generated = 0;
   int req_idle_pct     = IDLE_PCT;
   int rsp_stall_pct    = IDLE_PCT;

   bit start_holdoff = 1'b0;
   bit holdoff_done  = 1'b0;
   int unsigned holdoff_left = 0;

   // shadow distance calculator
   logic signed [ELEM_W-1:0] query_mem [MAX_DIMENSION_DEF];
   logic [DIM_REG_W-1:0]     model_dim;
   int                       model_pos;
   logic [ACC_W-1:0]         model_acc;

   // generator view of the stream, kept so no unwritten query entry is read
   bit query_written [MAX_DIMENSION_DEF];
   int gen_dim;
   int gen_pos;

   task automatic report_mismatch(string msg);
      if (mismatch_count < 100) begin
         $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   function automatic int eff_dim(logic [DIM_REG_W-1:0] d);
      if (d == '0) begin
         return 1;
      end
      if (d > MAX_DIMENSION_DEF) begin
         return MAX_DIMENSION_DEF;
      end
      return int'(d);
   endfunction

   // fold one accepted item into the shadow state, predicting a distance
   task automatic compute_distance(chunk_type c);
      int de;
      int pos;
      int d;
      logic signed [ELEM_W-1:0] e;
      distance_type r;
      de  = eff_dim(model_dim);
      pos = model_pos;
      if (pos >= de) begin
         pos = 0;
      end
      for (int k = 0; k < LANES_DEF; k++) begin
         if (pos + k < de) begin
            e = c.lanes[ELEM_W*k +: ELEM_W];
            if (c.cmd == CMD_DATABASE) begin
               d = int'(query_mem[pos+k]) - int'(e);
               model_acc = model_acc + ACC_W'(d * d);
            end else begin
               query_mem[pos+k] = e;
            end
         end
      end
      if (pos + LANES_DEF < de) begin
         model_pos = pos + LANES_DEF;
      end else begin
         model_pos = 0;
         if (c.cmd == CMD_DATABASE) begin
            r.distance   = model_acc[DIST_W-1:0];
            r.batch_done = c.batch_end;
            expected_distances.push_back(r);
            model_acc = '0;
         end
      end
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // request driver: valid is only lowered after an item is taken
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            compute_distance(pending_chunks[0]);
            void'(pending_chunks.pop_front());
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_chunks.size() > 0 && $urandom_range(99) >= req_idle_pct) begin
               req_chan.valid     <= 1'b1;
               req_chan.cmd       <= pending_chunks[0].cmd;
               req_chan.lane      <= pending_chunks[0].lanes;
               req_chan.batch_end <= pending_chunks[0].batch_end;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random stalls and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_distances.size() == 0) begin
               report_mismatch($sformatf("unexpected result distance=%0d batch_done=%0b",
                  rsp_chan.distance, rsp_chan.batch_done));
            end else begin
               if (rsp_chan.distance !== expected_distances[0].distance) begin
                  report_mismatch($sformatf("distance got %0d want %0d",
                     rsp_chan.distance, expected_distances[0].distance));
               end
               if (rsp_chan.batch_done !== expected_distances[0].batch_done) begin
                  report_mismatch($sformatf("batch_done got %0b want %0b",
                     rsp_chan.batch_done, expected_distances[0].batch_done));
               end
               void'(expected_distances.pop_front());
            end
         end
         if (start_holdoff && !holdoff_done) begin
            holdoff_done   <= 1'b1;
            holdoff_left   <= HOLDOFF_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else if (holdoff_left != 0) begin
            holdoff_left   <= holdoff_left - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // register write, setup then access phase
   task automatic write_csr(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == DIM_ADDR) begin
         model_dim = data[DIM_REG_W-1:0];
         model_pos = 0;
         model_acc = '0;
         gen_dim   = eff_dim(data[DIM_REG_W-1:0]);
         gen_pos   = 0;
      end
   endtask

   // wait until every item is taken and every distance has come back
   task automatic wait_idle();
      int guard;
      guard = 0;
      while ((pending_chunks.size() != 0 || expected_distances.size() != 0)
             && guard < IDLE_GUARD) begin
         @(negedge clock);
         guard++;
      end
      if (guard >= IDLE_GUARD) begin
         report_mismatch($sformatf("%0d distances never arrived",
            expected_distances.size()));
         expected_distances.delete();
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [ELEM_W-1:0] pick_elem();
      case ($urandom_range(7))
         0: return 8'h80;
         1: return 8'h7F;
         2: return 8'h00;
         3: return 8'hFF;
         default: return ELEM_W'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [LANE_BITS-1:0] rand_lanes();
      logic [LANE_BITS-1:0] v;
      for (int k = 0; k < LANES_DEF; k++) begin
         v[ELEM_W*k +: ELEM_W] = pick_elem();
      end
      return v;
   endfunction

   // queue one item and track position and written query entries
   task automatic push_chunk(logic cmd, logic [LANE_BITS-1:0] lanes, logic be);
      chunk_type c;
      int pos;
      pos = (gen_pos >= gen_dim) ? 0 : gen_pos;
      if (cmd == CMD_LOAD) begin
         for (int k = 0; k < LANES_DEF; k++) begin
            if (pos + k < gen_dim) begin
               query_written[pos+k] = 1'b1;
            end
         end
      end
      gen_pos     = (pos + LANES_DEF < gen_dim) ? pos + LANES_DEF : 0;
      c.cmd       = cmd;
      c.lanes     = lanes;
      c.batch_end = be;
      pending_chunks.push_back(c);
      chunks_generated++;
   endtask

   function automatic bit lanes_loaded();
      for (int k = 0; k < LANES_DEF; k++) begin
         if (gen_pos + k < gen_dim && !query_written[gen_pos+k]) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic bit query_complete();
      for (int p = 0; p < gen_dim; p++) begin
         if (!query_written[p]) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // database only where every lane read hits a loaded entry
   function automatic logic pick_cmd();
      if (lanes_loaded() && $urandom_range(1)) begin
         return CMD_DATABASE;
      end
      return CMD_LOAD;
   endfunction

   task automatic load_query();
      do push_chunk(CMD_LOAD, rand_lanes(), 1'($urandom_range(1)));
      while (gen_pos != 0);
   endtask

   // batch_end on inner items is noise; only the closing item counts
   task automatic db_vector();
      logic be;
      logic closing;
      be = ($urandom_range(3) == 0);
      do begin
         closing = (gen_pos + LANES_DEF >= gen_dim);
         push_chunk(CMD_DATABASE, rand_lanes(), closing ? be : 1'($urandom_range(1)));
      end while (gen_pos != 0);
   endtask

   // loads and database items interleaved within one vector
   task automatic mixed_vector();
      do push_chunk(pick_cmd(), rand_lanes(), 1'($urandom_range(1)));
      while (gen_pos != 0);
   endtask

   // a few items that leave the vector unfinished
   task automatic partial_tail();
      repeat ($urandom_range(1, 3)) begin
         if (gen_pos + LANES_DEF < gen_dim) begin
            push_chunk(pick_cmd(), rand_lanes(), 1'($urandom_range(1)));
         end
      end
   endtask

   task automatic random_phase(int n);
      int first;
      first = chunks_generated;
      while (chunks_generated - first < n) begin
         if (!query_complete()) begin
            load_query();
         end else begin
            case ($urandom_range(9))
               0, 1: load_query();
               2, 3: mixed_vector();
               default: db_vector();
            endcase
         end
      end
      if ($urandom_range(1)) begin
         partial_tail();
      end
   endtask

   // new dimension with junk in the unused upper bits, then random traffic
   task automatic run_phase(logic [DIM_REG_W-1:0] dim, int n, int idle_pct, bit holdoff);
      logic [CSR_DATA_W-1:0] word;
      word = {(CSR_DATA_W-DIM_REG_W)'($urandom), dim};
      write_csr(DIM_ADDR, word);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = idle_pct;
      random_phase(n);
      if (holdoff) begin
         start_holdoff = 1'b1;
      end
      wait_idle();
   endtask

   // stimulus sequence
   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.cmd       = CMD_LOAD;
      req_chan.lane      = '0;
      req_chan.batch_end = 1'b0;
      rsp_chan.ready     = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      model_dim          = DIM_RESET;
      model_pos          = 0;
      model_acc          = '0;
      gen_dim            = eff_dim(DIM_RESET);
      gen_pos            = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset dimension: extreme query against opposite extreme vector
      for (int i = 0; i < 16; i++) begin
         push_chunk(CMD_LOAD, (i < 8) ? {LANES_DEF{8'h80}} : {LANES_DEF{8'h7F}}, 1'(i));
      end
      for (int i = 0; i < 16; i++) begin
         push_chunk(CMD_DATABASE, (i < 8) ? {LANES_DEF{8'h7F}} : {LANES_DEF{8'h80}}, 1'b1);
      end
      wait_idle();

      // random traffic over a spread of dimensions
      run_phase(13'd8, 120, IDLE_PCT, 1'b1);
      run_phase(13'd9, 100, IDLE_PCT, 1'b0);
      run_phase(13'd0, 60, IDLE_PCT, 1'b0);

      // unfinished vector survives a write outside the register list
      write_csr(DIM_ADDR, CSR_DATA_W'(20));
      random_phase(100);
      partial_tail();
      wait_idle();
      write_csr(SPARE_ADDR, CSR_DATA_W'($urandom));
      random_phase(60);
      wait_idle();

      run_phase(13'd1, 40, 0, 1'b0);
      run_phase(13'd64, 150, 0, 1'b0);
      run_phase(13'd37, 100, IDLE_PCT, 1'b0);

      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // overall time limit
   initial begin
      #(TIMEOUT_NS);
      $display("Test completed with failures");
      $finish;
   end

endmodule

// File: files.f
design/l2d_pkg.sv
design/l2d_if.sv
design/l2d_qstore.sv
design/l2d_lane.sv
design/l2d_merge.sv
design/int8_squared_l2_distance.sv
tb/tb_int8_squared_l2_distance.sv
